// ===== src/pfde_pkg.sv =====
// shared types, op codes and default sizes for the page framebuffer draw engine
`default_nettype none

package pfde_pkg;

    // default geometry of the display store
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // field widths fixed by the command format
    localparam int OP_W    = 3;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int BCNT_W  = 4;
    localparam int PAGE_W  = 3;

    // command op codes
    localparam logic [OP_W-1:0] OP_POINT = 3'd0;
    localparam logic [OP_W-1:0] OP_FIELD = 3'd1;
    localparam logic [OP_W-1:0] OP_LINE  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the incoming transaction
        logic addr_load;   // load start and end address from the latched command
        logic addr_inc;    // step to the next byte of a sweep
        logic addr_page;   // step to the same column one page down
        logic mem_rd;      // register the byte at the current address
        logic mem_wr;      // write the byte at the current address
        logic wr_zero;     // written byte is zero instead of the merged byte
        logic hi_half;     // merge uses the upper half of the field mask
        logic out_load;    // load the result register
    } pfde_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic            straddle;
        logic            at_end;
        logic            out_free;
    } pfde_stat_t;

endpackage

`default_nettype wire

// ===== src/page_framebuffer_draw_engine_unit.sv =====
// Page-organized 1-bit frame store with a drawing engine (top level).
// Input channel: in_valid/in_stall with one command transaction (op, column, row_y,
// value, bit_count, fill, first_page, last_page). Output channel: out_valid/out_stall
// with one result transaction (read_data, status) per command, in command order.
// inverse_mode is written through cfg_write/cfg_data; the user must do so only while
// no command is in flight, as the block does not enforce it. One command is worked
// at a time: point and field are read-modify-writes (a field that spans two pages
// works both), a horizontal line does one read-modify-write per byte of its page,
// read reads one byte, out-of-range requests skip the store, and clear pages
// zeroes its pages, one byte written per cycle. All cost comes from the single-port
// frame store sequenced by the controller. A result shows on out_valid in the same
// cycle as in_stall drops. After reset the store is swept to zero with in_stall high.
// A stalled result is held in the output register; the next command is still
// accepted and worked, and waits at its end until the result register frees.
`default_nettype none

module page_framebuffer_draw_engine_unit
    import pfde_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic              cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [COL_W-1:0]  column,
    input  wire logic [ROW_W-1:0]  row_y,
    input  wire logic [BYTE_W-1:0] value,
    input  wire logic [BCNT_W-1:0] bit_count,
    input  wire logic              fill,
    input  wire logic [PAGE_W-1:0] first_page,
    input  wire logic [PAGE_W-1:0] last_page,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [BYTE_W-1:0]      read_data,
    output logic                   status
);

    pfde_cmd_t  cmd;
    pfde_stat_t stat;

    pfde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfde_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .op         (op),
        .column     (column),
        .row_y      (row_y),
        .value      (value),
        .bit_count  (bit_count),
        .fill       (fill),
        .first_page (first_page),
        .last_page  (last_page),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== src/pfde_datapath.sv =====
// datapath: command latch, range checks, address counter, frame store and result register
`default_nettype none

module pfde_datapath
    import pfde_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pfde_cmd_t         cmd,
    output pfde_stat_t             stat,
    input  wire logic              cfg_write,
    input  wire logic              cfg_data,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [COL_W-1:0]  column,
    input  wire logic [ROW_W-1:0]  row_y,
    input  wire logic [BYTE_W-1:0] value,
    input  wire logic [BCNT_W-1:0] bit_count,
    input  wire logic              fill,
    input  wire logic [PAGE_W-1:0] first_page,
    input  wire logic [PAGE_W-1:0] last_page,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [BYTE_W-1:0]      read_data,
    output logic                   status
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    // latched command
    logic [OP_W-1:0]   op_reg;
    logic [COL_W-1:0]  column_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [BYTE_W-1:0] value_reg;
    logic [BCNT_W-1:0] bcnt_reg;
    logic              fill_reg;
    logic [PAGE_W-1:0] fpage_reg;
    logic [PAGE_W-1:0] lpage_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            column_reg <= column;
            row_reg    <= row_y;
            value_reg  <= value;
            bcnt_reg   <= bit_count;
            fill_reg   <= fill;
            fpage_reg  <= first_page;
            lpage_reg  <= last_page;
        end
    end

    // inverse mode register
    logic inverse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inverse_reg <= 1'b0;
        else if (cfg_write)
            inverse_reg <= cfg_data;
    end

    // range checks on the latched command
    logic [PAGE_W-1:0] row_page;
    logic [2:0]        row_bit;
    logic              col_ok;
    logic              page_ok;
    logic              next_page_ok;
    logic              bits_ok;
    logic              straddle;
    logic              err;

    always_comb
    begin
        row_page     = row_reg[ROW_W-1:3];
        row_bit      = row_reg[2:0];
        col_ok       = 9'(column_reg) < 9'(COLUMNS);
        page_ok      = 5'(row_page) < 5'(PAGES);
        next_page_ok = (5'(row_page) + 5'd1) < 5'(PAGES);
        bits_ok      = bcnt_reg inside {[4'd1:4'd8]};
        straddle     = (5'(bcnt_reg) + 5'(row_bit)) > 5'd8;
        case (op_reg)
            OP_POINT: err = !(col_ok && page_ok);
            OP_FIELD: err = !(col_ok && page_ok && bits_ok && (!straddle || next_page_ok));
            OP_LINE:  err = !page_ok;
            OP_CLEAR: err = !((fpage_reg <= lpage_reg) && (5'(lpage_reg) < 5'(PAGES)));
            OP_READ:  err = !(col_ok && (5'(fpage_reg) < 5'(PAGES)));
            default:  err = 1'b1;
        endcase
    end

    // start and end address of the access or sweep
    logic              is_sweep;
    logic [PAGE_W-1:0] start_page;
    logic [PAGE_W-1:0] end_page;
    logic [AW-1:0]     start_addr;
    logic [AW-1:0]     end_addr;

    always_comb
    begin
        is_sweep   = (op_reg == OP_LINE) || (op_reg == OP_CLEAR);
        start_page = ((op_reg == OP_CLEAR) || (op_reg == OP_READ)) ? fpage_reg : row_page;
        end_page   = (op_reg == OP_CLEAR) ? lpage_reg : row_page;
        start_addr = AW'(start_page) * AW'(COLUMNS)
                   + (is_sweep ? AW'(0) : AW'(column_reg));
        end_addr   = AW'(end_page) * AW'(COLUMNS) + AW'(COLUMNS - 1);
    end

    // address counter, reset to cover the whole store for the power-up clear
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            end_reg  <= AW'(DEPTH - 1);
        end
        else if (cmd.addr_load)
        begin
            addr_reg <= start_addr;
            end_reg  <= end_addr;
        end
        else if (cmd.addr_inc)
            addr_reg <= addr_reg + AW'(1);
        else if (cmd.addr_page)
            addr_reg <= addr_reg + AW'(COLUMNS);
    end

    // bit mask and data of the write, spread over two pages
    logic [BYTE_W-1:0]   field_msk;
    logic [2*BYTE_W-1:0] mask16;
    logic [2*BYTE_W-1:0] data16;
    logic [BYTE_W-1:0]   mask8;
    logic [BYTE_W-1:0]   data8;
    logic                set_pix;

    always_comb
    begin
        field_msk = BYTE_W'((9'd1 << bcnt_reg) - 9'd1);
        set_pix   = fill_reg ^ inverse_reg;
        case (op_reg)
            OP_FIELD:
            begin
                mask16 = 16'(field_msk) << row_bit;
                data16 = 16'(value_reg & field_msk) << row_bit;
            end
            OP_POINT:
            begin
                mask16 = 16'd1 << row_bit;
                data16 = set_pix ? mask16 : '0;
            end
            default:
            begin
                mask16 = 16'd1 << row_bit;
                data16 = mask16;
            end
        endcase
        mask8 = cmd.hi_half ? mask16[15:8] : mask16[7:0];
        data8 = cmd.hi_half ? data16[15:8] : data16[7:0];
    end

    // frame store with registered read
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic [BYTE_W-1:0] wdata;

    assign wdata = cmd.wr_zero ? '0 : ((rdata_reg & ~mask8) | (data8 & mask8));

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[addr_reg] <= wdata;
        if (cmd.mem_rd)
            rdata_reg <= mem[addr_reg];
    end

    // result register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] read_data_reg;
    logic              status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_data_reg <= (!err && (op_reg == OP_READ)) ? rdata_reg : '0;
            status_reg    <= err;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    // status back to the controller
    always_comb
    begin
        stat.op       = op_reg;
        stat.err      = err;
        stat.straddle = straddle;
        stat.at_end   = addr_reg == end_reg;
        stat.out_free = !out_valid_reg || !out_stall;
    end

endmodule

`default_nettype wire

// ===== src/pfde_ctrl.sv =====
// controller: sequences power-up clear, read-modify-write, sweeps and result hand-off
`default_nettype none

module pfde_ctrl
    import pfde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire pfde_stat_t stat,
    output pfde_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_WRITE,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   hi_reg;
    logic   hi_next;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        hi_next     = hi_reg;
        cmd         = '0;
        cmd.hi_half = hi_reg;
        in_stall    = state_reg != ST_IDLE;
        case (state_reg)
            ST_INIT_CLR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_zero = 1'b1;
                if (stat.at_end)
                    state_next = ST_IDLE;
                else
                    cmd.addr_inc = 1'b1;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                hi_next       = 1'b0;
                cmd.addr_load = 1'b1;
                if (stat.err)
                    state_next = ST_FINISH;
                else if (stat.op == OP_CLEAR)
                    state_next = ST_CLEAR;
                else
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = (stat.op == OP_READ) ? ST_FINISH : ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                case (stat.op)
                    OP_FIELD:
                    begin
                        if (stat.straddle && !hi_reg)
                        begin
                            hi_next       = 1'b1;
                            cmd.addr_page = 1'b1;
                            state_next    = ST_READ;
                        end
                        else
                            state_next = ST_FINISH;
                    end
                    OP_LINE:
                    begin
                        if (stat.at_end)
                            state_next = ST_FINISH;
                        else
                        begin
                            cmd.addr_inc = 1'b1;
                            state_next   = ST_READ;
                        end
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_CLEAR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_zero = 1'b1;
                if (stat.at_end)
                    state_next = ST_FINISH;
                else
                    cmd.addr_inc = 1'b1;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_CLR;
            hi_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hi_reg    <= hi_next;
        end
    end

endmodule

`default_nettype wire
